// ===== rtl/core/hbd_pkg.sv =====
// Types, codes and address decode helpers of the handheld bus decoder.
`timescale 1ns / 1ps
package hbd_pkg;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_SPEED = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    TGT_LOCAL   = 4'd0,
    TGT_CART    = 4'd1,
    TGT_JOYPAD  = 4'd2,
    TGT_SERIAL  = 4'd3,
    TGT_TIMER   = 4'd4,
    TGT_IRQ     = 4'd5,
    TGT_AUDIO   = 4'd6,
    TGT_LCD     = 4'd7,
    TGT_DROPPED = 4'd8
  } target_t;

  typedef enum logic [2:0] {
    RD_ZERO  = 3'd0,
    RD_VRAM  = 3'd1,
    RD_WRAM  = 3'd2,
    RD_HIGH  = 3'd3,
    RD_CONST = 3'd4
  } rd_sel_t;

  typedef enum logic {
    ST_CLEAR = 1'b0,
    ST_RUN   = 1'b1
  } state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] bus_addr;
    logic [7:0]  wr_byte;
    logic        oam_dma_busy;
    logic        audio_powered;
  } in_t;

  typedef struct packed {
    logic [7:0]  rd_byte;
    logic [3:0]  target;
    logic [15:0] fwd_addr;
    logic [7:0]  fwd_byte;
    logic        packet_valid;
    logic [1:0]  packet_bits;
    logic        dma_start;
    logic        boot_rom_off;
    logic        video_written;
    logic        double_speed;
    logic        speed_changed;
  } out_t;

  localparam logic [15:0] ECHO_OFFSET = 16'h2000;
  localparam logic [15:0] ADDR_SPEED  = 16'hFF4D;
  localparam logic [15:0] ADDR_DMA    = 16'hFF46;
  localparam logic [15:0] ADDR_VBANK  = 16'hFF4F;
  localparam logic [15:0] ADDR_BOOT   = 16'hFF50;
  localparam logic [15:0] ADDR_WBANK  = 16'hFF70;
  localparam logic [7:0]  VBANK_FILL  = 8'hFE;
  localparam logic [7:0]  WBANK_FILL  = 8'hF8;
  localparam logic [7:0]  AUDIO_MASK  = 8'h3F;
  localparam logic [7:0]  OAM_BUSY    = 8'hFF;
  localparam int          HIGH_DEPTH  = 512;
  localparam int          VRAM_DEPTH  = 16384;
  localparam int          WRAM_DEPTH  = 32768;

  function automatic target_t io_target(input logic [15:0] a);
    target_t t;
    t = TGT_LOCAL;
    if (a == 16'hFF00) t = TGT_JOYPAD;
    else if (a <= 16'hFF02) t = TGT_SERIAL;
    else if (a == 16'hFF03) t = TGT_LOCAL;
    else if (a <= 16'hFF07) t = TGT_TIMER;
    else if (a <= 16'hFF0E) t = TGT_LOCAL;
    else if (a == 16'hFF0F) t = TGT_IRQ;
    else if (a <= 16'hFF3F) t = TGT_AUDIO;
    else if (a <= 16'hFF45) t = TGT_LCD;
    else if (a == 16'hFF46) t = TGT_LOCAL;
    else if (a <= 16'hFF4B) t = TGT_LCD;
    else if (a <= 16'hFF67) t = TGT_LOCAL;
    else if (a <= 16'hFF6C) t = TGT_LCD;
    else if (a == 16'hFFFF) t = TGT_IRQ;
    return t;
  endfunction

endpackage

// ===== rtl/core/hbd_in_if.sv =====
// Input channel of the bus decoder: valid, ready and one bus access.
`timescale 1ns / 1ps
interface hbd_in_if;
  logic          valid;
  logic          ready;
  hbd_pkg::in_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/hbd_out_if.sv =====
// Result channel of the bus decoder: valid, ready and one decode result.
`timescale 1ns / 1ps
interface hbd_out_if;
  logic          valid;
  logic          ready;
  hbd_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/hbd_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module hbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/core/handheld_bus_decoder_banked_ram_unit.sv =====
// Top level of the handheld bus decoder with banked video and work RAM.
//
//  channel  | dir | handshake        | payload
//  in_ch    | in  | valid / ready    | action, bus_addr, wr_byte, oam_dma_busy, audio_powered
//  out_ch   | out | valid / ready    | rd_byte, target, fwd_addr, fwd_byte, flags
//  cfg_*    | in  | cfg_we only      | cfg_idx selects color_mode / super_mode
//
// An access goes through accept (RAM access), read data back and result transfer, in that order.
// Next access is accepted once the result register has been taken.
// After reset the 512-byte high store is cleared, one entry per cycle; in_ch.ready stays
// low during that sweep. Configuration writes are taken on any cfg_we outside reset.
// A stalled result holds in the output register.
`timescale 1ns / 1ps
module handheld_bus_decoder_banked_ram_unit (
  input  logic       clk,
  input  logic       rst_n,
  hbd_in_if.sink     in_ch,
  hbd_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic       cfg_idx,
  input  logic       cfg_wdata
);
  localparam int HAW = $clog2(hbd_pkg::HIGH_DEPTH);
  localparam int VAW = $clog2(hbd_pkg::VRAM_DEPTH);
  localparam int WAW = $clog2(hbd_pkg::WRAM_DEPTH);

  hbd_pkg::state_t state_r, state_nxt;
  logic [HAW-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic            clearing;

  logic       color_r, super_r;
  logic       vbank_r, vbank_nxt;
  logic [2:0] wbank_r, wbank_nxt;
  logic       flag_r, flag_nxt;
  logic       armed_r, armed_nxt;

  logic              stage_valid_r;
  hbd_pkg::out_t     stage_r;
  hbd_pkg::rd_sel_t  sel_r;
  hbd_pkg::out_t     stage_fill;
  logic              out_valid_r;
  hbd_pkg::out_t     out_r;

  logic              in_fire;
  logic [15:0]       a;
  hbd_pkg::out_t     dec;
  hbd_pkg::rd_sel_t  dec_sel;
  hbd_pkg::target_t  tgt;
  logic [7:0]        v;
  logic              vram_we, wram_we, high_we;
  logic [VAW-1:0]    vram_addr;
  logic [WAW-1:0]    wram_addr;
  logic [HAW-1:0]    high_addr;
  logic [7:0]        high_wdata;
  logic              high_we_q;
  logic [7:0]        vram_rd, wram_rd, high_rd;
  logic              is_cart;

  // clearing sweep
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hbd_pkg::ST_CLEAR: if (clr_cnt_r == HAW'(hbd_pkg::HIGH_DEPTH - 1)) begin
        state_nxt = hbd_pkg::ST_RUN;
      end
      hbd_pkg::ST_RUN: state_nxt = hbd_pkg::ST_RUN;
      default: state_nxt = hbd_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    clearing    = (state_r == hbd_pkg::ST_CLEAR);
    clr_cnt_nxt = clearing ? clr_cnt_r + HAW'(1) : clr_cnt_r;
  end

  assign in_ch.ready = !clearing && !stage_valid_r && !out_valid_r;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign a = (in_ch.data.bus_addr >= 16'hE000 && in_ch.data.bus_addr <= 16'hFDFF)
           ? in_ch.data.bus_addr - hbd_pkg::ECHO_OFFSET : in_ch.data.bus_addr;
  assign is_cart   = (a <= 16'h7FFF) || (a >= 16'hA000 && a <= 16'hBFFF);
  assign vram_addr = {vbank_r, a[VAW-2:0]};
  assign wram_addr = (a < 16'hD000) ? {3'd0, a[11:0]} : {wbank_r, a[11:0]};

  // access decode
  always_comb begin
    dec       = '0;
    dec_sel   = hbd_pkg::RD_ZERO;
    tgt       = hbd_pkg::TGT_LOCAL;
    v         = in_ch.data.wr_byte;
    vram_we   = 1'b0;
    wram_we   = 1'b0;
    high_we   = 1'b0;
    vbank_nxt = vbank_r;
    wbank_nxt = wbank_r;
    flag_nxt  = flag_r;
    armed_nxt = armed_r;
    case (hbd_pkg::action_t'(in_ch.data.action))
      hbd_pkg::ACT_READ: begin
        if (is_cart) tgt = hbd_pkg::TGT_CART;
        else if (a <= 16'h9FFF) dec_sel = hbd_pkg::RD_VRAM;
        else if (a <= 16'hDFFF) dec_sel = hbd_pkg::RD_WRAM;
        else if (a <= 16'hFE9F && in_ch.data.oam_dma_busy) begin
          dec_sel     = hbd_pkg::RD_CONST;
          dec.rd_byte = hbd_pkg::OAM_BUSY;
        end else if (a < 16'hFF00) dec_sel = hbd_pkg::RD_HIGH;
        else if (a == hbd_pkg::ADDR_SPEED) begin
          dec_sel     = hbd_pkg::RD_CONST;
          dec.rd_byte = {flag_r, 6'd0, armed_r};
        end else begin
          tgt = hbd_pkg::io_target(a);
          if (tgt == hbd_pkg::TGT_LOCAL) dec_sel = hbd_pkg::RD_HIGH;
        end
        if (tgt != hbd_pkg::TGT_LOCAL) dec.fwd_addr = a;
      end
      hbd_pkg::ACT_WRITE: begin
        if (is_cart) tgt = hbd_pkg::TGT_CART;
        else if (a <= 16'h9FFF) begin
          vram_we           = 1'b1;
          dec.video_written = 1'b1;
        end else if (a <= 16'hDFFF) wram_we = 1'b1;
        else if (a < 16'hFF00) high_we = 1'b1;
        else begin
          tgt = hbd_pkg::io_target(a);
          if (tgt == hbd_pkg::TGT_LOCAL) begin
            high_we = 1'b1;
            if (a == hbd_pkg::ADDR_DMA) dec.dma_start = 1'b1;
            else if (a == hbd_pkg::ADDR_SPEED) begin
              if (v[0]) armed_nxt = 1'b1;
            end else if (a == hbd_pkg::ADDR_VBANK) begin
              vbank_nxt = v[0];
              v         = v | hbd_pkg::VBANK_FILL;
            end else if (a == hbd_pkg::ADDR_BOOT) dec.boot_rom_off = v[0];
            else if (a == hbd_pkg::ADDR_WBANK) begin
              if (v[2:0] == 3'd0) v[0] = 1'b1;
              wbank_nxt = v[2:0];
              v         = v | hbd_pkg::WBANK_FILL;
            end
          end else if (tgt == hbd_pkg::TGT_JOYPAD) begin
            if (super_r) begin
              dec.packet_valid = 1'b1;
              dec.packet_bits  = v[5:4];
            end
          end else if (tgt == hbd_pkg::TGT_AUDIO && a <= 16'hFF25
                       && !in_ch.data.audio_powered && !color_r) begin
            if (a == 16'hFF11 || a == 16'hFF16 || a == 16'hFF20) v = v & hbd_pkg::AUDIO_MASK;
            else if (a != 16'hFF1B) tgt = hbd_pkg::TGT_DROPPED;
          end
        end
        if (tgt != hbd_pkg::TGT_LOCAL && tgt != hbd_pkg::TGT_DROPPED) begin
          dec.fwd_addr = a;
          dec.fwd_byte = v;
        end
      end
      hbd_pkg::ACT_SPEED: begin
        if (armed_r) begin
          flag_nxt          = !flag_r;
          armed_nxt         = 1'b0;
          dec.speed_changed = 1'b1;
        end
      end
      default: ;
    endcase
    dec.target       = tgt;
    dec.double_speed = flag_nxt;
  end

  assign high_addr  = clearing ? clr_cnt_r : a[HAW-1:0];
  assign high_wdata = clearing ? 8'd0 : v;
  assign high_we_q  = clearing || (in_fire && high_we);

  hbd_ram #(.WIDTH(8), .DEPTH(hbd_pkg::VRAM_DEPTH)) u_vram (
    .clk(clk), .we(in_fire && vram_we), .addr(vram_addr), .wdata(v), .rdata(vram_rd)
  );
  hbd_ram #(.WIDTH(8), .DEPTH(hbd_pkg::WRAM_DEPTH)) u_wram (
    .clk(clk), .we(in_fire && wram_we), .addr(wram_addr), .wdata(v), .rdata(wram_rd)
  );
  hbd_ram #(.WIDTH(8), .DEPTH(hbd_pkg::HIGH_DEPTH)) u_high (
    .clk(clk), .we(high_we_q), .addr(high_addr), .wdata(high_wdata), .rdata(high_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= hbd_pkg::ST_CLEAR;
      clr_cnt_r     <= '0;
      color_r       <= 1'b0;
      super_r       <= 1'b0;
      vbank_r       <= 1'b0;
      wbank_r       <= 3'd1;
      flag_r        <= 1'b0;
      armed_r       <= 1'b0;
      stage_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      if (cfg_we) begin
        if (cfg_idx) super_r <= cfg_wdata;
        else color_r <= cfg_wdata;
      end
      if (in_fire) begin
        vbank_r <= vbank_nxt;
        wbank_r <= wbank_nxt;
        flag_r  <= flag_nxt;
        armed_r <= armed_nxt;
      end
      stage_valid_r <= in_fire;
      if (stage_valid_r) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    stage_fill = stage_r;
    case (sel_r)
      hbd_pkg::RD_VRAM:  stage_fill.rd_byte = vram_rd;
      hbd_pkg::RD_WRAM:  stage_fill.rd_byte = wram_rd;
      hbd_pkg::RD_HIGH:  stage_fill.rd_byte = high_rd;
      hbd_pkg::RD_CONST: stage_fill.rd_byte = stage_r.rd_byte;
      default:           stage_fill.rd_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stage_r <= dec;
      sel_r   <= dec_sel;
    end
    if (stage_valid_r) begin
      out_r <= stage_fill;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;
endmodule

// ===== verif/handheld_bus_decoder_banked_ram_unit_tb.sv =====
// Self-checking testbench of the handheld bus decoder with banked video and work RAM.
`timescale 1ns / 1ps
module handheld_bus_decoder_banked_ram_unit_tb;
  import hbd_pkg::*;

  localparam logic CFG_COLOR = 1'b0;
  localparam logic CFG_SUPER = 1'b1;
  localparam int   STALL_LIMIT = 3000;
  localparam int   ITEMS_PER_PHASE = 340;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_idx;
  logic cfg_wdata;

  hbd_in_if  in_ch ();
  hbd_out_if out_ch ();

  handheld_bus_decoder_banked_ram_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // accesses waiting to be driven and decode results waiting to arrive
  in_t  access_q[$];
  out_t decode_q[$];

  // predictor copy of the block
  logic [7:0] vram_m[VRAM_DEPTH];
  logic [7:0] wram_m[WRAM_DEPTH];
  logic [7:0] high_m[HIGH_DEPTH];
  logic       vbank_m;
  logic [2:0] wbank_m;
  logic       speed_m;
  logic       armed_m;
  logic       color_m;
  logic       super_m;

  // generator shadow: banks and written entries, to keep reads on written RAM
  bit         vram_seen[VRAM_DEPTH];
  bit         wram_seen[WRAM_DEPTH];
  logic       gen_vbank;
  logic [2:0] gen_wbank;

  int  errors;
  bit  idle_on;
  bit  in_fired;
  int  in_gap;
  int  out_gap;
  int  stall_cnt;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [15:0] fold_echo(input logic [15:0] a);
    if (a >= 16'hE000 && a <= 16'hFDFF) return a - ECHO_OFFSET;
    return a;
  endfunction

  function automatic target_t port_target(input logic [15:0] a);
    logic [7:0] lo;
    lo = a[7:0];
    if (a == 16'hFFFF) return TGT_IRQ;
    if (lo == 8'h00) return TGT_JOYPAD;
    if (lo == 8'h01 || lo == 8'h02) return TGT_SERIAL;
    if (lo >= 8'h04 && lo <= 8'h07) return TGT_TIMER;
    if (lo == 8'h0F) return TGT_IRQ;
    if (lo >= 8'h10 && lo <= 8'h3F) return TGT_AUDIO;
    if ((lo >= 8'h40 && lo <= 8'h45) || (lo >= 8'h47 && lo <= 8'h4B)) return TGT_LCD;
    if (lo >= 8'h68 && lo <= 8'h6C) return TGT_LCD;
    return TGT_LOCAL;
  endfunction

  function automatic bit is_cart(input logic [15:0] a);
    return a <= 16'h7FFF || (a >= 16'hA000 && a <= 16'hBFFF);
  endfunction

  task automatic decode_access(input in_t acc, output out_t res);
    logic [15:0] a;
    logic [7:0]  v;
    target_t     tgt;
    bit          keep;
    a    = fold_echo(acc.bus_addr);
    v    = acc.wr_byte;
    tgt  = TGT_LOCAL;
    keep = 1'b0;
    res  = '0;
    case (action_t'(acc.action))
      ACT_READ: begin
        if (is_cart(a)) tgt = TGT_CART;
        else if (a <= 16'h9FFF) res.rd_byte = vram_m[{vbank_m, a[12:0]}];
        else if (a <= 16'hCFFF) res.rd_byte = wram_m[{3'd0, a[11:0]}];
        else if (a <= 16'hDFFF) res.rd_byte = wram_m[{wbank_m, a[11:0]}];
        else if (a <= 16'hFE9F && acc.oam_dma_busy) res.rd_byte = OAM_BUSY;
        else if (a < 16'hFF00) res.rd_byte = high_m[a[8:0]];
        else if (a == ADDR_SPEED) res.rd_byte = {speed_m, 6'd0, armed_m};
        else begin
          tgt = port_target(a);
          if (tgt == TGT_LOCAL) res.rd_byte = high_m[a[8:0]];
        end
        if (tgt != TGT_LOCAL) res.fwd_addr = a;
      end
      ACT_WRITE: begin
        if (is_cart(a)) tgt = TGT_CART;
        else if (a <= 16'h9FFF) begin
          vram_m[{vbank_m, a[12:0]}] = v;
          res.video_written = 1'b1;
        end else if (a <= 16'hCFFF) wram_m[{3'd0, a[11:0]}] = v;
        else if (a <= 16'hDFFF) wram_m[{wbank_m, a[11:0]}] = v;
        else if (a < 16'hFF00) keep = 1'b1;
        else begin
          tgt = port_target(a);
          if (tgt == TGT_LOCAL) begin
            keep = 1'b1;
            if (a == ADDR_DMA) res.dma_start = 1'b1;
            else if (a == ADDR_SPEED) begin
              if (v[0]) armed_m = 1'b1;
            end else if (a == ADDR_VBANK) begin
              vbank_m = v[0];
              v = v | VBANK_FILL;
            end else if (a == ADDR_BOOT) res.boot_rom_off = v[0];
            else if (a == ADDR_WBANK) begin
              if (v[2:0] == 3'b000) v[0] = 1'b1;
              wbank_m = v[2:0];
              v = v | WBANK_FILL;
            end
          end else if (tgt == TGT_JOYPAD) begin
            if (super_m) begin
              res.packet_valid = 1'b1;
              res.packet_bits  = v[5:4];
            end
          end else if (tgt == TGT_AUDIO && a <= 16'hFF25 && !acc.audio_powered && !color_m) begin
            if (a == 16'hFF11 || a == 16'hFF16 || a == 16'hFF20) v = v & AUDIO_MASK;
            else if (a != 16'hFF1B) tgt = TGT_DROPPED;
          end
        end
        if (keep) high_m[a[8:0]] = v;
        if (tgt != TGT_LOCAL && tgt != TGT_DROPPED) begin
          res.fwd_addr = a;
          res.fwd_byte = v;
        end
      end
      ACT_SPEED: begin
        if (armed_m) begin
          speed_m = ~speed_m;
          armed_m = 1'b0;
          res.speed_changed = 1'b1;
        end
      end
      default: ;
    endcase
    res.target       = tgt;
    res.double_speed = speed_m;
  endtask

  // queue an access; a read of never-written RAM becomes a write
  task automatic push_access(input action_t act, input logic [15:0] addr, input logic [7:0] wb,
                             input logic dma, input logic apu);
    in_t         acc;
    logic [15:0] a;
    a = fold_echo(addr);
    if (act == ACT_READ) begin
      if (a >= 16'h8000 && a <= 16'h9FFF && !vram_seen[{gen_vbank, a[12:0]}]) act = ACT_WRITE;
      if (a >= 16'hC000 && a <= 16'hCFFF && !wram_seen[{3'd0, a[11:0]}]) act = ACT_WRITE;
      if (a >= 16'hD000 && a <= 16'hDFFF && !wram_seen[{gen_wbank, a[11:0]}]) act = ACT_WRITE;
    end
    if (act == ACT_WRITE) begin
      if (a >= 16'h8000 && a <= 16'h9FFF) vram_seen[{gen_vbank, a[12:0]}] = 1'b1;
      if (a >= 16'hC000 && a <= 16'hCFFF) wram_seen[{3'd0, a[11:0]}] = 1'b1;
      if (a >= 16'hD000 && a <= 16'hDFFF) wram_seen[{gen_wbank, a[11:0]}] = 1'b1;
      if (a == ADDR_VBANK) gen_vbank = wb[0];
      if (a == ADDR_WBANK) gen_wbank = (wb[2:0] == 3'b000) ? 3'd1 : wb[2:0];
    end
    acc.action        = act;
    acc.bus_addr      = addr;
    acc.wr_byte       = wb;
    acc.oam_dma_busy  = dma;
    acc.audio_powered = apu;
    access_q.push_back(acc);
  endtask

  task automatic push_random;
    int          sel;
    int          pick;
    action_t     act;
    logic [15:0] addr;
    logic [15:0] base;
    logic [15:0] span;
    sel  = $urandom_range(0, 99);
    pick = $urandom_range(0, 99);
    if (pick < 45) act = ACT_READ;
    else if (pick < 90) act = ACT_WRITE;
    else if (pick < 97) act = ACT_SPEED;
    else act = ACT_NONE;
    if (sel < 20) begin
      span = ($urandom_range(0, 3) != 0) ? 16'd31 : 16'h1FFF;
      addr = 16'h8000 + 16'($urandom_range(0, span));
    end else if (sel < 40) begin
      case ($urandom_range(0, 3))
        0: base = 16'hC000;
        1: base = 16'hD000;
        2: base = 16'hE000;
        default: base = 16'hF000;
      endcase
      span = ($urandom_range(0, 3) != 0) ? 16'd31 : 16'h0FFF;
      if (base == 16'hF000 && span > 16'h0DFF) span = 16'h0DFF;
      addr = base + 16'($urandom_range(0, span));
    end else if (sel < 50) addr = 16'hFE00 + 16'($urandom_range(0, 255));
    else if (sel < 70) addr = 16'hFF00 + 16'($urandom_range(0, 127));
    else if (sel < 75) addr = 16'hFF80 + 16'($urandom_range(0, 127));
    else if (sel < 82) begin
      case ($urandom_range(0, 2))
        0: addr = ADDR_VBANK;
        1: addr = ADDR_WBANK;
        default: addr = ADDR_SPEED;
      endcase
    end else if (sel < 87) begin
      addr = $urandom_range(0, 1) ? 16'($urandom_range(0, 16'h7FFF))
                                  : 16'hA000 + 16'($urandom_range(0, 16'h1FFF));
    end else addr = 16'($urandom_range(0, 16'hFFFF));
    push_access(act, addr, 8'($urandom_range(0, 255)), ($urandom_range(0, 9) < 3),
                1'($urandom_range(0, 1)));
  endtask

  task automatic push_directed;
    push_access(ACT_READ,  16'h0000, 8'h00, 1'b0, 1'b0);
    push_access(ACT_READ,  16'hFFFF, 8'h00, 1'b0, 1'b0);
    push_access(ACT_WRITE, 16'h8000, 8'hFF, 1'b0, 1'b0);
    push_access(ACT_READ,  16'h8000, 8'h00, 1'b0, 1'b0);
    push_access(ACT_WRITE, ADDR_VBANK, 8'h01, 1'b0, 1'b0);
    push_access(ACT_WRITE, 16'h9FFF, 8'h5A, 1'b0, 1'b0);
    push_access(ACT_READ,  16'h9FFF, 8'h00, 1'b0, 1'b0);
    push_access(ACT_WRITE, ADDR_WBANK, 8'h00, 1'b0, 1'b0);
    push_access(ACT_READ,  ADDR_WBANK, 8'h00, 1'b0, 1'b0);
    push_access(ACT_WRITE, 16'hD000, 8'hAA, 1'b0, 1'b0);
    push_access(ACT_READ,  16'hF000, 8'h00, 1'b0, 1'b0);
    push_access(ACT_WRITE, 16'hFE9F, 8'h77, 1'b1, 1'b0);
    push_access(ACT_READ,  16'hFE00, 8'h00, 1'b1, 1'b0);
    push_access(ACT_READ,  16'hFE9F, 8'h00, 1'b0, 1'b0);
    push_access(ACT_WRITE, 16'hFF00, 8'h30, 1'b0, 1'b0);
    push_access(ACT_WRITE, 16'hFF11, 8'hFF, 1'b0, 1'b0);
    push_access(ACT_WRITE, 16'hFF1B, 8'hC3, 1'b0, 1'b0);
    push_access(ACT_WRITE, 16'hFF12, 8'h81, 1'b0, 1'b0);
    push_access(ACT_WRITE, 16'hFF26, 8'h80, 1'b0, 1'b0);
    push_access(ACT_SPEED, 16'h0000, 8'h00, 1'b0, 1'b0);
    push_access(ACT_WRITE, ADDR_SPEED, 8'h01, 1'b0, 1'b0);
    push_access(ACT_SPEED, 16'hFFFF, 8'hFF, 1'b1, 1'b1);
    push_access(ACT_WRITE, ADDR_DMA, 8'hC0, 1'b0, 1'b1);
    push_access(ACT_WRITE, ADDR_BOOT, 8'h01, 1'b0, 1'b0);
    push_access(ACT_WRITE, 16'hFF55, 8'h8F, 1'b0, 1'b0);
    push_access(ACT_NONE,  16'hFFFF, 8'hFF, 1'b1, 1'b1);
  endtask

  task automatic write_cfg(input logic idx, input logic val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    if (idx == CFG_COLOR) color_m = val;
    else super_m = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain;
    @(posedge clk);
    while (access_q.size() != 0 || decode_q.size() != 0 || in_ch.valid) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic field_chk(input string name, input logic [15:0] exp_v, input logic [15:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  // driver: input channel
  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || in_fired)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(0, 4);
        in_ch.valid <= 1'b0;
      end else if (access_q.size() != 0) begin
        in_ch.data  <= access_q.pop_front();
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // driver: result channel stalls
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap--;
      out_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_gap = $urandom_range(0, 4);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    out_t res;
    out_t exp_r;
    in_fired = rst_n && in_ch.valid && in_ch.ready;
    if (in_fired) begin
      decode_access(in_ch.data, res);
      decode_q.push_back(res);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (decode_q.size() == 0) begin
        $display("%0t: unexpected transfer, actual %0h", $time, out_ch.data);
        errors++;
      end else begin
        exp_r = decode_q.pop_front();
        field_chk("rd_byte",       exp_r.rd_byte,       out_ch.data.rd_byte);
        field_chk("target",        exp_r.target,        out_ch.data.target);
        field_chk("fwd_addr",      exp_r.fwd_addr,      out_ch.data.fwd_addr);
        field_chk("fwd_byte",      exp_r.fwd_byte,      out_ch.data.fwd_byte);
        field_chk("packet_valid",  exp_r.packet_valid,  out_ch.data.packet_valid);
        field_chk("packet_bits",   exp_r.packet_bits,   out_ch.data.packet_bits);
        field_chk("dma_start",     exp_r.dma_start,     out_ch.data.dma_start);
        field_chk("boot_rom_off",  exp_r.boot_rom_off,  out_ch.data.boot_rom_off);
        field_chk("video_written", exp_r.video_written, out_ch.data.video_written);
        field_chk("double_speed",  exp_r.double_speed,  out_ch.data.double_speed);
        field_chk("speed_changed", exp_r.speed_changed, out_ch.data.speed_changed);
      end
      stall_cnt = 0;
    end else if (in_fired) begin
      stall_cnt = 0;
    end else begin
      stall_cnt++;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    errors      = 0;
    idle_on     = 1'b1;
    in_fired    = 1'b0;
    in_gap      = 0;
    out_gap     = 0;
    stall_cnt   = 0;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = CFG_COLOR;
    cfg_wdata   = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    out_ch.ready = 1'b0;
    foreach (high_m[i]) high_m[i] = 8'h00;
    foreach (vram_m[i]) vram_m[i] = 8'h00;
    foreach (wram_m[i]) wram_m[i] = 8'h00;
    vbank_m   = 1'b0;
    wbank_m   = 3'd1;
    speed_m   = 1'b0;
    armed_m   = 1'b0;
    color_m   = 1'b0;
    super_m   = 1'b0;
    gen_vbank = 1'b0;
    gen_wbank = 3'd1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    push_directed();
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      write_cfg(CFG_COLOR, (ph == 1 || ph == 3));
      write_cfg(CFG_SUPER, (ph == 1 || ph == 2));
      if (ph == 4) idle_on = 1'b0;
      if (ph == 1) push_directed();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) push_random();
      drain();
    end
    repeat (10) @(posedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
